@@ hw/rtl/hevc_config_record_parser_assert.svh @@
// Assertion helpers shared by the hvcC record parser modules.
// Each macro is followed by a semicolon-free use on a line of its own.
`ifndef HEVC_CONFIG_RECORD_PARSER_ASSERT_SVH
`define HEVC_CONFIG_RECORD_PARSER_ASSERT_SVH
`ifndef SYNTH
`define HCRP_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define HCRP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HCRP_ASSERT(lbl, clk, rst, prop, msg)
`define HCRP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

@@ hw/rtl/hcrp_pkg.sv @@
package hcrp_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [4:0]  field_id;
    logic [47:0] value;
    logic [7:0]  array_number;
    logic [15:0] unit_number;
    logic        record_end;
  } result_t;

  typedef enum logic [2:0] {
    KIND_HEADER   = 3'd0,
    KIND_ARRAY    = 3'd1,
    KIND_ULEN     = 3'd2,
    KIND_PAYLOAD  = 3'd3,
    KIND_NOT_HVCC = 3'd4,
    KIND_TRUNC    = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    PH_WAIT,
    PH_HEADER,
    PH_ARRAY,
    PH_ULEN,
    PH_PAYLOAD,
    PH_IDLE
  } phase_t;

  // How the back end expands one queued command into result words.
  typedef enum logic [2:0] {
    OP_ONE,
    OP_FIRST,
    OP_PAIR,
    OP_B21,
    OP_ARR
  } op_t;

  typedef struct packed {
    op_t         op;
    kind_t       kind;
    logic [4:0]  id;
    logic        lo3;
    logic [47:0] value;
    logic [7:0]  data;
    logic [7:0]  array_number;
    logic [15:0] unit_number;
    logic        last;
  } cmd_t;

  localparam logic [4:0] FID_VERSION       = 5'd0;
  localparam logic [4:0] FID_PROFILE_SPACE = 5'd1;
  localparam logic [4:0] FID_TIER          = 5'd2;
  localparam logic [4:0] FID_PROFILE_IDC   = 5'd3;
  localparam logic [4:0] FID_COMPAT        = 5'd4;
  localparam logic [4:0] FID_CONSTRAINT    = 5'd5;
  localparam logic [4:0] FID_LEVEL         = 5'd6;
  localparam logic [4:0] FID_RSV0          = 5'd7;
  localparam logic [4:0] FID_MIN_SEG       = 5'd8;
  localparam logic [4:0] FID_RSV1          = 5'd9;
  localparam logic [4:0] FID_RSV2          = 5'd11;
  localparam logic [4:0] FID_RSV3          = 5'd13;
  localparam logic [4:0] FID_RSV4          = 5'd15;
  localparam logic [4:0] FID_FRAME_RATE    = 5'd17;
  localparam logic [4:0] FID_CONST_RATE    = 5'd18;
  localparam logic [4:0] FID_TEMP_LAYERS   = 5'd19;
  localparam logic [4:0] FID_TEMP_NESTED   = 5'd20;
  localparam logic [4:0] FID_LEN_SIZE      = 5'd21;
  localparam logic [4:0] FID_NUM_ARRAYS    = 5'd22;
  localparam logic [4:0] FID_COMPLETE      = 5'd23;
  localparam logic [4:0] FID_ARR_RSV       = 5'd24;
  localparam logic [4:0] FID_NAL_TYPE      = 5'd25;
  localparam logic [4:0] FID_NUM_UNITS     = 5'd26;

endpackage

@@ hw/rtl/hcrp_front.sv @@
`include "hevc_config_record_parser_assert.svh"

module hcrp_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  hcrp_pkg::item_t item,
  output logic            cmd_push,
  output hcrp_pkg::cmd_t  cmd
);
  import hcrp_pkg::*;

  // Byte positions within the 23-byte header.
  localparam logic [4:0] HB_COMPAT_END  = 5'd5;
  localparam logic [4:0] HB_CONSTR_END  = 5'd11;
  localparam logic [4:0] HB_LEVEL       = 5'd12;
  localparam logic [4:0] HB_SEG_HI      = 5'd13;
  localparam logic [4:0] HB_SEG_LO      = 5'd14;
  localparam logic [4:0] HB_PAR         = 5'd15;
  localparam logic [4:0] HB_CHROMA      = 5'd16;
  localparam logic [4:0] HB_LUMA        = 5'd17;
  localparam logic [4:0] HB_CDEPTH      = 5'd18;
  localparam logic [4:0] HB_RATE_HI     = 5'd19;
  localparam logic [4:0] HB_RATE_LO     = 5'd20;
  localparam logic [4:0] HB_FLAGS       = 5'd21;
  localparam logic [4:0] HB_NUM_ARRAYS  = 5'd22;
  localparam logic [4:0] HB_FIRST_FREE  = 5'd3;
  localparam logic [4:0] HB_DECIDE      = 5'd2;
  // Byte positions within an array header and a unit length.
  localparam logic [4:0] AB_FLAGS       = 5'd0;
  localparam logic [4:0] AB_COUNT_HI    = 5'd1;
  localparam logic [4:0] AB_COUNT_LO    = 5'd2;
  localparam logic [4:0] LB_HI          = 5'd0;
  localparam logic [4:0] LB_LO          = 5'd1;

  phase_t      phase, phase_next;
  logic [4:0]  hbc, hbc_next;
  logic [15:0] first_bytes, first_bytes_next;
  logic [47:0] field_acc, field_acc_next;
  logic [7:0]  arrays_left, arrays_left_next;
  logic [15:0] units_left, units_left_next;
  logic [15:0] payload_left, payload_left_next;
  logic [7:0]  array_counter, array_counter_next;
  logic [15:0] unit_counter, unit_counter_next;
  logic [7:0]  length_high_byte, length_high_byte_next;

  logic [7:0]  b;
  logic        fin;
  logic        parsing;
  logic        emit;
  logic        complete;
  logic        do_unit;
  logic        do_array;
  logic [47:0] acc_sh;
  logic [15:0] array_units;
  logic [15:0] unit_len;
  logic [15:0] units_dec;
  logic [7:0]  arrays_dec;
  logic [15:0] payload_dec;

  assign b           = item.data_byte;
  assign fin         = item.final_byte;
  assign parsing     = (phase != PH_WAIT) && (phase != PH_IDLE);
  assign acc_sh      = {field_acc[39:0], b};
  assign array_units = {field_acc[7:0], b};
  assign unit_len    = {length_high_byte, b};
  assign units_dec   = units_left - 16'd1;
  assign arrays_dec  = arrays_left - 8'd1;
  assign payload_dec = payload_left - 16'd1;

  always_comb begin
    phase_next            = phase;
    hbc_next              = hbc;
    first_bytes_next      = first_bytes;
    field_acc_next        = field_acc;
    arrays_left_next      = arrays_left;
    units_left_next       = units_left;
    payload_left_next     = payload_left;
    array_counter_next    = array_counter;
    unit_counter_next     = unit_counter;
    length_high_byte_next = length_high_byte;
    emit     = 1'b0;
    complete = 1'b0;
    do_unit  = 1'b0;
    do_array = 1'b0;
    cmd      = '0;
    cmd.op   = OP_ONE;
    cmd.kind = KIND_HEADER;

    case (phase)
      PH_WAIT: begin
        first_bytes_next = {first_bytes[7:0], b};
        if (fin) begin
          emit     = 1'b1;
          cmd.kind = KIND_NOT_HVCC;
        end else if (hbc < HB_DECIDE) begin
          hbc_next = hbc + 5'd1;
        end else if (first_bytes == 16'h0000 && b <= 8'd1) begin
          // Annex B start code: not a configuration record.
          emit       = 1'b1;
          cmd.kind   = KIND_NOT_HVCC;
          phase_next = PH_IDLE;
        end else begin
          emit           = 1'b1;
          cmd.op         = OP_FIRST;
          cmd.value      = 48'(first_bytes[15:8]);
          cmd.data       = first_bytes[7:0];
          field_acc_next = 48'(b);
          hbc_next       = HB_FIRST_FREE;
          phase_next     = PH_HEADER;
        end
      end
      PH_HEADER: begin
        field_acc_next = acc_sh;
        hbc_next       = hbc + 5'd1;
        case (hbc)
          HB_COMPAT_END: begin
            emit           = 1'b1;
            cmd.id         = FID_COMPAT;
            cmd.value      = acc_sh;
            field_acc_next = '0;
          end
          HB_CONSTR_END: begin
            emit           = 1'b1;
            cmd.id         = FID_CONSTRAINT;
            cmd.value      = acc_sh;
            field_acc_next = '0;
          end
          HB_LEVEL: begin
            emit           = 1'b1;
            cmd.id         = FID_LEVEL;
            cmd.value      = 48'(b);
            field_acc_next = '0;
          end
          HB_SEG_HI: begin
            emit           = 1'b1;
            cmd.id         = FID_RSV0;
            cmd.value      = 48'(b[7:4]);
            field_acc_next = 48'(b[3:0]);
          end
          HB_SEG_LO: begin
            emit           = 1'b1;
            cmd.id         = FID_MIN_SEG;
            cmd.value      = acc_sh;
            field_acc_next = '0;
          end
          HB_PAR: begin
            emit           = 1'b1;
            cmd.op         = OP_PAIR;
            cmd.id         = FID_RSV1;
            cmd.data       = b;
            field_acc_next = '0;
          end
          HB_CHROMA: begin
            emit           = 1'b1;
            cmd.op         = OP_PAIR;
            cmd.id         = FID_RSV2;
            cmd.data       = b;
            field_acc_next = '0;
          end
          HB_LUMA: begin
            emit           = 1'b1;
            cmd.op         = OP_PAIR;
            cmd.id         = FID_RSV3;
            cmd.lo3        = 1'b1;
            cmd.data       = b;
            field_acc_next = '0;
          end
          HB_CDEPTH: begin
            emit           = 1'b1;
            cmd.op         = OP_PAIR;
            cmd.id         = FID_RSV4;
            cmd.lo3        = 1'b1;
            cmd.data       = b;
            field_acc_next = '0;
          end
          HB_RATE_HI: begin
            field_acc_next = 48'(b);
          end
          HB_RATE_LO: begin
            emit           = 1'b1;
            cmd.id         = FID_FRAME_RATE;
            cmd.value      = acc_sh;
            field_acc_next = '0;
          end
          HB_FLAGS: begin
            emit           = 1'b1;
            cmd.op         = OP_B21;
            cmd.data       = b;
            field_acc_next = '0;
          end
          HB_NUM_ARRAYS: begin
            emit               = 1'b1;
            cmd.id             = FID_NUM_ARRAYS;
            cmd.value          = 48'(b);
            field_acc_next     = '0;
            arrays_left_next   = b;
            array_counter_next = '0;
            hbc_next           = '0;
            if (b == 8'd0) begin
              complete   = 1'b1;
              phase_next = PH_IDLE;
            end else begin
              phase_next = PH_ARRAY;
            end
          end
          default: ;
        endcase
      end
      PH_ARRAY: begin
        case (hbc)
          AB_FLAGS: begin
            emit             = 1'b1;
            cmd.op           = OP_ARR;
            cmd.kind         = KIND_ARRAY;
            cmd.data         = b;
            cmd.array_number = array_counter;
            hbc_next         = AB_COUNT_HI;
          end
          AB_COUNT_HI: begin
            field_acc_next = 48'(b);
            hbc_next       = AB_COUNT_LO;
          end
          default: begin
            emit              = 1'b1;
            cmd.kind          = KIND_ARRAY;
            cmd.id            = FID_NUM_UNITS;
            cmd.value         = 48'(array_units);
            cmd.array_number  = array_counter;
            field_acc_next    = '0;
            units_left_next   = array_units;
            unit_counter_next = '0;
            hbc_next          = AB_FLAGS;
            if (array_units == 16'd0) begin
              do_array = 1'b1;
            end else begin
              phase_next = PH_ULEN;
            end
          end
        endcase
      end
      PH_ULEN: begin
        if (hbc == LB_HI) begin
          length_high_byte_next = b;
          hbc_next              = LB_LO;
        end else begin
          emit              = 1'b1;
          cmd.kind          = KIND_ULEN;
          cmd.value         = 48'(unit_len);
          cmd.array_number  = array_counter;
          cmd.unit_number   = unit_counter;
          payload_left_next = unit_len;
          hbc_next          = LB_HI;
          if (unit_len == 16'd0) begin
            do_unit = 1'b1;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        emit              = 1'b1;
        cmd.kind          = KIND_PAYLOAD;
        cmd.value         = 48'(b);
        cmd.array_number  = array_counter;
        cmd.unit_number   = unit_counter;
        payload_left_next = payload_dec;
        if (payload_dec == 16'd0) begin
          do_unit = 1'b1;
        end
      end
      default: ;
    endcase

    // A finished unit may close its array, which may close the record.
    if (do_unit) begin
      units_left_next   = units_dec;
      unit_counter_next = unit_counter + 16'd1;
      hbc_next          = '0;
      if (units_dec == 16'd0) begin
        do_array = 1'b1;
      end else begin
        phase_next = PH_ULEN;
      end
    end
    if (do_array) begin
      arrays_left_next   = arrays_dec;
      array_counter_next = array_counter + 8'd1;
      hbc_next           = '0;
      if (arrays_dec == 8'd0) begin
        complete   = 1'b1;
        phase_next = PH_IDLE;
      end else begin
        phase_next = PH_ARRAY;
      end
    end

    // A buffer that ends inside the record replaces this byte's words.
    if (parsing && fin && !complete) begin
      cmd      = '0;
      cmd.op   = OP_ONE;
      cmd.kind = KIND_TRUNC;
      emit     = 1'b1;
    end
    cmd.last = emit && (complete || cmd.kind == KIND_NOT_HVCC || cmd.kind == KIND_TRUNC);

    if (fin) begin
      phase_next = PH_WAIT;
      hbc_next   = '0;
    end
  end

  assign cmd_push = accept && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_WAIT;
      hbc   <= '0;
    end else if (accept) begin
      phase <= phase_next;
      hbc   <= hbc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      first_bytes      <= first_bytes_next;
      field_acc        <= field_acc_next;
      arrays_left      <= arrays_left_next;
      units_left       <= units_left_next;
      payload_left     <= payload_left_next;
      array_counter    <= array_counter_next;
      unit_counter     <= unit_counter_next;
      length_high_byte <= length_high_byte_next;
    end
  end

  `HCRP_ASSERT(a_trunc_on_final, clk, rst, cmd_push && cmd.kind == KIND_TRUNC |-> item.final_byte, "truncated status without a final byte")
  `HCRP_ASSERT(a_final_rearms, clk, rst, accept && item.final_byte |=> phase == PH_WAIT && hbc == 5'd0, "final byte did not rearm the parser")
  `HCRP_ASSERT(a_status_ends, clk, rst, cmd_push && (cmd.kind == KIND_NOT_HVCC || cmd.kind == KIND_TRUNC) |-> cmd.last, "status word without record end")

endmodule

@@ hw/rtl/hcrp_queue.sv @@
`include "hevc_config_record_parser_assert.svh"

module hcrp_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  hcrp_pkg::cmd_t wr_data,
  output logic           full,
  input  logic           rd,
  output hcrp_pkg::cmd_t rd_data,
  output logic           empty
);
  import hcrp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, wr_ptr_next;
  logic [PTR_W-1:0] rd_ptr, rd_ptr_next;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  assign wr_ptr_next = (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
  assign rd_ptr_next = (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= wr_ptr_next;
      end
      if (rd) begin
        rd_ptr <= rd_ptr_next;
      end
      if (wr && !rd) begin
        count <= count + CNT_W'(1);
      end else if (rd && !wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  `HCRP_ASSERT(a_no_overflow, clk, rst, wr |-> !full, "write into a full command queue")
  `HCRP_ASSERT(a_no_underflow, clk, rst, rd |-> !empty, "read from an empty command queue")
  `HCRP_ASSERT(a_count_up, clk, rst, wr && !rd |=> count == $past(count) + CNT_W'(1), "queue count did not advance on write")
  `HCRP_ASSERT_ALWAYS(a_reset_clears, clk, rst |=> empty && !full, "queue not cleared by reset")

endmodule

@@ hw/rtl/hcrp_back.sv @@
`include "hevc_config_record_parser_assert.svh"

module hcrp_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  hcrp_pkg::cmd_t    head,
  output logic              head_pop,
  input  logic              pop,
  output logic              empty,
  output hcrp_pkg::result_t result
);
  import hcrp_pkg::*;

  logic [1:0] sub;
  logic [1:0] last_sub;
  logic       load;
  logic       out_valid;
  result_t    out_word;
  result_t    res;
  logic [7:0] d;

  // Index of the final word that a command expands into.
  function automatic logic [1:0] op_last_sub(input op_t op);
    logic [1:0] n;
    case (op)
      OP_FIRST: n = 2'd3;
      OP_PAIR:  n = 2'd1;
      OP_B21:   n = 2'd3;
      OP_ARR:   n = 2'd2;
      default:  n = 2'd0;
    endcase
    return n;
  endfunction

  assign d        = head.data;
  assign last_sub = op_last_sub(head.op);
  assign load     = head_valid && (!out_valid || pop);
  assign head_pop = load && (sub == last_sub);

  always_comb begin
    res              = '0;
    res.kind         = head.kind;
    res.field_id     = head.id;
    res.value        = head.value;
    res.array_number = head.array_number;
    res.unit_number  = head.unit_number;
    res.record_end   = head.last && (sub == last_sub);
    case (head.op)
      OP_FIRST: begin
        case (sub)
          2'd0: begin
            res.field_id = FID_VERSION;
            res.value    = head.value;
          end
          2'd1: begin
            res.field_id = FID_PROFILE_SPACE;
            res.value    = 48'(d[7:6]);
          end
          2'd2: begin
            res.field_id = FID_TIER;
            res.value    = 48'(d[5]);
          end
          default: begin
            res.field_id = FID_PROFILE_IDC;
            res.value    = 48'(d[4:0]);
          end
        endcase
      end
      OP_PAIR: begin
        if (sub == 2'd0) begin
          res.field_id = head.id;
          res.value    = head.lo3 ? 48'(d[7:3]) : 48'(d[7:2]);
        end else begin
          res.field_id = head.id + 5'd1;
          res.value    = head.lo3 ? 48'(d[2:0]) : 48'(d[1:0]);
        end
      end
      OP_B21: begin
        case (sub)
          2'd0: begin
            res.field_id = FID_CONST_RATE;
            res.value    = 48'(d[7:6]);
          end
          2'd1: begin
            res.field_id = FID_TEMP_LAYERS;
            res.value    = 48'(d[5:3]);
          end
          2'd2: begin
            res.field_id = FID_TEMP_NESTED;
            res.value    = 48'(d[2]);
          end
          default: begin
            res.field_id = FID_LEN_SIZE;
            res.value    = 48'(d[1:0]);
          end
        endcase
      end
      OP_ARR: begin
        case (sub)
          2'd0: begin
            res.field_id = FID_COMPLETE;
            res.value    = 48'(d[7]);
          end
          2'd1: begin
            res.field_id = FID_ARR_RSV;
            res.value    = 48'(d[6]);
          end
          default: begin
            res.field_id = FID_NAL_TYPE;
            res.value    = 48'(d[5:0]);
          end
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sub       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        sub       <= head_pop ? 2'd0 : sub + 2'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_word <= res;
    end
  end

  assign empty  = !out_valid;
  assign result = out_word;

  `HCRP_ASSERT(a_sub_in_range, clk, rst, head_valid |-> sub <= last_sub, "word index past the end of its command")
  `HCRP_ASSERT(a_end_on_pop, clk, rst, load && res.record_end |-> head_pop, "record end before the last word of a command")
  `HCRP_ASSERT(a_sub_restart, clk, rst, head_pop |=> sub == 2'd0, "word index not restarted after a command")

endmodule

@@ hw/rtl/hevc_config_record_parser.sv @@
// hvcC decoder configuration record parser.
// Input channel: one record byte per word (data_byte, final_byte), taken when
// push is high and full is low. final_byte marks the last byte of the buffer;
// after it the parser rearms for the next record.
// Result channel: a queue-like port; the oldest word shows on result while
// empty is low and leaves when pop is high. Header bytes that carry several
// fields give up to four words, in record order; a status word (not hvcC or
// truncated) always carries record_end.
// Throughput: one byte per cycle while full is low. The back end issues one
// result word per cycle while the receiver keeps up, so a byte that expands
// into n words holds the back end until all n are issued; the command queue of
// QUEUE_DEPTH entries takes bytes meanwhile, and full rises only once it fills.
// The first word of a byte goes through the command queue and then the output
// register before it shows on result.
// Reset (rst, synchronous) empties the queue and the output register and puts
// the parser back to wait for the first byte. When the receiver stalls, the
// output word holds, the queue fills, and full then stalls the sender.
module hevc_config_record_parser #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  hcrp_pkg::item_t   item,
  output logic              empty,
  input  logic              pop,
  output hcrp_pkg::result_t result
);
  import hcrp_pkg::*;

  logic accept;
  logic cmd_push;
  cmd_t cmd;
  logic q_full;
  logic q_empty;
  logic q_pop;
  cmd_t q_head;

  assign accept = push && !q_full;
  assign full   = q_full;

  hcrp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .item     (item),
    .cmd_push (cmd_push),
    .cmd      (cmd)
  );

  hcrp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (cmd_push),
    .wr_data (cmd),
    .full    (q_full),
    .rd      (q_pop),
    .rd_data (q_head),
    .empty   (q_empty)
  );

  hcrp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (!q_empty),
    .head       (q_head),
    .head_pop   (q_pop),
    .pop        (pop),
    .empty      (empty),
    .result     (result)
  );

endmodule

@@ test/hevc_config_record_parser_test.sv @@
module hevc_config_record_parser_test;
  import hcrp_pkg::*;

  // Field codes that the package leaves unnamed, and the code for words with no field.
  localparam logic [4:0] FID_NONE         = 5'd0;
  localparam logic [4:0] FID_PARALLELISM  = 5'd10;
  localparam logic [4:0] FID_CHROMA_FMT   = 5'd12;
  localparam logic [4:0] FID_LUMA_DEPTH   = 5'd14;
  localparam logic [4:0] FID_CHROMA_DEPTH = 5'd16;

  localparam int STALL_AT     = 200;
  localparam int STALL_CYCLES = 300;
  localparam int MAX_PRINTED  = 200;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    push = 1'b0;
  logic    pop = 1'b0;
  item_t   item = '0;
  logic    full;
  logic    empty;
  result_t result;

  hevc_config_record_parser u_top (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  always #6 clk = ~clk;

  // Parser state as the block should hold it.
  phase_t      ph = PH_WAIT;
  logic [4:0]  hdr_idx;
  logic [23:0] lead_bytes;
  logic [47:0] acc;
  logic [7:0]  arrays_left;
  logic [15:0] units_left;
  logic [15:0] bytes_left;
  logic [7:0]  arr_no;
  logic [15:0] unit_no;
  logic [7:0]  len_hi;

  result_t step_words[$];
  result_t expected_words[$];
  bit      rec_done;

  item_t      pending_bytes[$];
  logic [7:0] rec[$];

  int errors = 0;
  int bytes_in = 0;
  int words_seen = 0;
  int completes = 0;
  int truncs = 0;
  int rejects = 0;

  bit byte_went = 1'b0;
  bit word_went = 1'b0;
  int send_hold = 0;
  bit send_calm = 1'b0;
  int send_run = 0;
  int take_hold = 0;
  bit take_calm = 1'b0;
  int take_run = 0;
  int stall_left = 0;
  bit stall_done = 1'b0;

  function automatic void reset_parser();
    ph = PH_WAIT;
    hdr_idx = '0;
    lead_bytes = '0;
    acc = '0;
    arrays_left = '0;
    units_left = '0;
    bytes_left = '0;
    arr_no = '0;
    unit_no = '0;
    len_hi = '0;
  endfunction

  function automatic void note_word(kind_t k, logic [4:0] id, logic [47:0] v,
                                    logic [7:0] a, logic [15:0] u);
    result_t w;
    if (step_words.size() < 4) begin
      w.kind = k;
      w.field_id = id;
      w.value = v;
      w.array_number = a;
      w.unit_number = u;
      w.record_end = 1'b0;
      step_words.push_back(w);
    end
  endfunction

  function automatic void end_record();
    rec_done = 1'b1;
    ph = PH_IDLE;
  endfunction

  function automatic void end_array();
    arrays_left = arrays_left - 8'd1;
    arr_no = arr_no + 8'd1;
    hdr_idx = '0;
    if (arrays_left == 0) end_record();
    else ph = PH_ARRAY;
  endfunction

  function automatic void end_unit();
    units_left = units_left - 16'd1;
    unit_no = unit_no + 16'd1;
    hdr_idx = '0;
    if (units_left == 0) end_array();
    else ph = PH_ULEN;
  endfunction

  function automatic void take_header(int idx, logic [7:0] b);
    acc = {acc[39:0], b};
    case (idx)
      0: begin
        note_word(KIND_HEADER, FID_VERSION, 48'(b), '0, '0);
        acc = '0;
      end
      1: begin
        note_word(KIND_HEADER, FID_PROFILE_SPACE, 48'(b[7:6]), '0, '0);
        note_word(KIND_HEADER, FID_TIER, 48'(b[5]), '0, '0);
        note_word(KIND_HEADER, FID_PROFILE_IDC, 48'(b[4:0]), '0, '0);
        acc = '0;
      end
      5: begin
        note_word(KIND_HEADER, FID_COMPAT, acc, '0, '0);
        acc = '0;
      end
      11: begin
        note_word(KIND_HEADER, FID_CONSTRAINT, acc, '0, '0);
        acc = '0;
      end
      12: begin
        note_word(KIND_HEADER, FID_LEVEL, 48'(b), '0, '0);
        acc = '0;
      end
      13: begin
        // The low nibble opens the 12-bit segmentation field.
        note_word(KIND_HEADER, FID_RSV0, 48'(b[7:4]), '0, '0);
        acc = 48'(b[3:0]);
      end
      14: begin
        note_word(KIND_HEADER, FID_MIN_SEG, acc, '0, '0);
        acc = '0;
      end
      15: begin
        note_word(KIND_HEADER, FID_RSV1, 48'(b[7:2]), '0, '0);
        note_word(KIND_HEADER, FID_PARALLELISM, 48'(b[1:0]), '0, '0);
        acc = '0;
      end
      16: begin
        note_word(KIND_HEADER, FID_RSV2, 48'(b[7:2]), '0, '0);
        note_word(KIND_HEADER, FID_CHROMA_FMT, 48'(b[1:0]), '0, '0);
        acc = '0;
      end
      17: begin
        note_word(KIND_HEADER, FID_RSV3, 48'(b[7:3]), '0, '0);
        note_word(KIND_HEADER, FID_LUMA_DEPTH, 48'(b[2:0]), '0, '0);
        acc = '0;
      end
      18: begin
        note_word(KIND_HEADER, FID_RSV4, 48'(b[7:3]), '0, '0);
        note_word(KIND_HEADER, FID_CHROMA_DEPTH, 48'(b[2:0]), '0, '0);
        acc = '0;
      end
      19: acc = 48'(b);
      20: begin
        note_word(KIND_HEADER, FID_FRAME_RATE, acc, '0, '0);
        acc = '0;
      end
      21: begin
        note_word(KIND_HEADER, FID_CONST_RATE, 48'(b[7:6]), '0, '0);
        note_word(KIND_HEADER, FID_TEMP_LAYERS, 48'(b[5:3]), '0, '0);
        note_word(KIND_HEADER, FID_TEMP_NESTED, 48'(b[2]), '0, '0);
        note_word(KIND_HEADER, FID_LEN_SIZE, 48'(b[1:0]), '0, '0);
        acc = '0;
      end
      22: begin
        note_word(KIND_HEADER, FID_NUM_ARRAYS, 48'(b), '0, '0);
        acc = '0;
        arrays_left = b;
        arr_no = '0;
        hdr_idx = '0;
        if (b == 0) end_record();
        else ph = PH_ARRAY;
        return;
      end
      default: ;
    endcase
    hdr_idx = 5'(idx + 1);
  endfunction

  // Works out the words that one accepted byte must produce.
  function automatic void parse_byte(item_t it);
    logic [7:0] b;
    bit         fin;
    bit         busy;
    result_t    w;
    b = it.data_byte;
    fin = it.final_byte;
    step_words.delete();
    rec_done = 1'b0;
    busy = (ph != PH_WAIT) && (ph != PH_IDLE);
    case (ph)
      PH_WAIT: begin
        lead_bytes = {lead_bytes[15:0], b};
        if (fin) begin
          note_word(KIND_NOT_HVCC, FID_NONE, '0, '0, '0);
        end else if (hdr_idx < 2) begin
          hdr_idx = hdr_idx + 5'd1;
        end else if (lead_bytes[23:16] == 0 && lead_bytes[15:8] == 0 && b <= 1) begin
          note_word(KIND_NOT_HVCC, FID_NONE, '0, '0, '0);
          ph = PH_IDLE;
        end else begin
          acc = '0;
          take_header(0, lead_bytes[23:16]);
          take_header(1, lead_bytes[15:8]);
          take_header(2, b);
          ph = PH_HEADER;
        end
      end
      PH_HEADER: take_header(int'(hdr_idx), b);
      PH_ARRAY: begin
        if (hdr_idx == 0) begin
          note_word(KIND_ARRAY, FID_COMPLETE, 48'(b[7]), arr_no, '0);
          note_word(KIND_ARRAY, FID_ARR_RSV, 48'(b[6]), arr_no, '0);
          note_word(KIND_ARRAY, FID_NAL_TYPE, 48'(b[5:0]), arr_no, '0);
          hdr_idx = 5'd1;
        end else if (hdr_idx == 1) begin
          acc = 48'(b);
          hdr_idx = 5'd2;
        end else begin
          units_left = {acc[7:0], b};
          acc = '0;
          note_word(KIND_ARRAY, FID_NUM_UNITS, 48'(units_left), arr_no, '0);
          unit_no = '0;
          hdr_idx = '0;
          if (units_left == 0) end_array();
          else ph = PH_ULEN;
        end
      end
      PH_ULEN: begin
        if (hdr_idx == 0) begin
          len_hi = b;
          hdr_idx = 5'd1;
        end else begin
          bytes_left = {len_hi, b};
          note_word(KIND_ULEN, FID_NONE, 48'(bytes_left), arr_no, unit_no);
          hdr_idx = '0;
          if (bytes_left == 0) end_unit();
          else ph = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        note_word(KIND_PAYLOAD, FID_NONE, 48'(b), arr_no, unit_no);
        bytes_left = bytes_left - 16'd1;
        if (bytes_left == 0) end_unit();
      end
      default: ;
    endcase

    // A final mark inside an unfinished record replaces this byte's words.
    if (busy && fin && !rec_done) begin
      step_words.delete();
      note_word(KIND_TRUNC, FID_NONE, '0, '0, '0);
    end
    if (step_words.size() > 0) begin
      w = step_words[step_words.size() - 1];
      if (rec_done || w.kind >= KIND_NOT_HVCC) begin
        w.record_end = 1'b1;
        step_words[step_words.size() - 1] = w;
      end
      if (w.kind == KIND_NOT_HVCC) rejects++;
      if (w.kind == KIND_TRUNC) truncs++;
    end
    if (rec_done) completes++;
    foreach (step_words[i]) expected_words.push_back(step_words[i]);
    if (fin) reset_parser();
  endfunction

  task automatic flag(string what);
    errors++;
    if (errors <= MAX_PRINTED) $display("mismatch at %0t: %s", $time, what);
  endtask

  function automatic int draw_gap(inout bit calm, inout int run);
    if (run == 0) begin
      calm = ($urandom_range(0, 3) == 0);
      run = $urandom_range(8, 40);
    end
    run--;
    return calm ? 0 : $urandom_range(0, 8);
  endfunction

  // Both handshakes are sampled here, at the rising edge.
  always @(posedge clk) begin
    result_t want;
    byte_went <= !rst && push && !full;
    word_went <= !rst && pop && !empty;
    if (rst) begin
      reset_parser();
    end else begin
      if (push && !full) begin
        parse_byte(item);
        bytes_in++;
      end
      if (pop && !empty) begin
        words_seen++;
        if (expected_words.size() == 0) begin
          flag($sformatf("word %0d arrived with nothing expected", words_seen));
        end else begin
          want = expected_words.pop_front();
          if (result.kind !== want.kind)
            flag($sformatf("word %0d kind %0d, expected %0d",
                           words_seen, result.kind, want.kind));
          if (result.field_id !== want.field_id)
            flag($sformatf("word %0d field_id %0d, expected %0d",
                           words_seen, result.field_id, want.field_id));
          if (result.value !== want.value)
            flag($sformatf("word %0d value %0h, expected %0h",
                           words_seen, result.value, want.value));
          if (result.array_number !== want.array_number)
            flag($sformatf("word %0d array_number %0d, expected %0d",
                           words_seen, result.array_number, want.array_number));
          if (result.unit_number !== want.unit_number)
            flag($sformatf("word %0d unit_number %0d, expected %0d",
                           words_seen, result.unit_number, want.unit_number));
          if (result.record_end !== want.record_end)
            flag($sformatf("word %0d record_end %0d, expected %0d",
                           words_seen, result.record_end, want.record_end));
        end
      end
    end
  end

  // Byte driver.
  always @(negedge clk) begin
    if (!rst) begin
      if (push && byte_went) send_hold = draw_gap(send_calm, send_run);
      if (!push || byte_went) begin
        if (send_hold > 0) begin
          send_hold--;
          push <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          item <= pending_bytes.pop_front();
          push <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Result receiver, with one long hold-off so that the block backs up.
  always @(negedge clk) begin
    if (!rst) begin
      if (pop && word_went) take_hold = draw_gap(take_calm, take_run);
      if (!stall_done && bytes_in >= STALL_AT) begin
        stall_done = 1'b1;
        stall_left = STALL_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (take_hold > 0) begin
        take_hold--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  function automatic void queue_byte(logic [7:0] b, bit fin);
    item_t it;
    it.data_byte = b;
    it.final_byte = fin;
    pending_bytes.push_back(it);
  endfunction

  // Builds a well-formed record in rec; fill < 0 gives a random header.
  function automatic void build_record(int n_arr, int unit_cap, int len_cap, int fill);
    int units;
    int len;
    rec.delete();
    for (int i = 0; i < 23; i++) rec.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
    if (rec[0] == 0 && rec[1] == 0 && rec[2] <= 1) rec[2] = 8'h02;
    rec[22] = 8'(n_arr);
    for (int a = 0; a < n_arr; a++) begin
      rec.push_back(8'($urandom));
      units = $urandom_range(0, unit_cap);
      rec.push_back(8'(units >> 8));
      rec.push_back(8'(units));
      for (int u = 0; u < units; u++) begin
        len = $urandom_range(0, len_cap);
        rec.push_back(8'(len >> 8));
        rec.push_back(8'(len));
        for (int p = 0; p < len; p++) rec.push_back(8'($urandom));
      end
    end
  endfunction

  // Sends the first keep bytes of rec; a whole record may carry trailing bytes.
  function automatic void ship(int keep, int trail);
    int n;
    int total;
    logic [7:0] b;
    n = (keep < rec.size()) ? keep : rec.size();
    total = n + ((n == rec.size()) ? trail : 0);
    for (int i = 0; i < total; i++) begin
      b = (i < n) ? rec[i] : 8'($urandom);
      queue_byte(b, i == total - 1);
    end
  endfunction

  initial begin
    int pick;
    int n;
    bit lead_zero;
    logic [7:0] b;

    // Short buffers and start codes.
    queue_byte(8'h5A, 1'b1);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b1);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b1);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hAB, 1'b0);
    queue_byte(8'hCD, 1'b1);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h01, 1'b0);
    queue_byte(8'hEE, 1'b1);
    // Final mark on the first byte after the decision.
    queue_byte(8'h01, 1'b0);
    queue_byte(8'h02, 1'b0);
    queue_byte(8'h03, 1'b0);
    queue_byte(8'h04, 1'b1);

    // Zero-filled header, byte 2 apart, with no arrays, ending on its last byte.
    build_record(0, 0, 0, 0);
    ship(rec.size(), 0);
    // All-ones header: maximum counts and length, cut off in the payload.
    build_record(0, 0, 0, 255);
    rec[22] = 8'hFF;
    repeat (5) rec.push_back(8'hFF);
    repeat (3) rec.push_back(8'($urandom));
    ship(rec.size(), 0);
    // Final mark on the array count byte of a record that has arrays.
    build_record(2, 1, 1, -1);
    ship(23, 0);
    // Arrays with no units, then trailing bytes.
    build_record(2, 0, 0, -1);
    ship(rec.size(), 3);
    // Units of zero length.
    build_record(1, 3, 0, -1);
    ship(rec.size(), 0);
    // Leading bytes that look like, but are not, a start code.
    build_record(1, 2, 3, -1);
    rec[0] = 8'h00;
    rec[1] = 8'h01;
    rec[2] = 8'h00;
    ship(rec.size(), 0);
    build_record(2, 1, 2, -1);
    rec[0] = 8'h01;
    rec[1] = 8'h00;
    rec[2] = 8'h00;
    ship(rec.size(), 2);
    build_record(3, 3, 4, -1);
    ship(rec.size(), 0);

    while (pending_bytes.size() < 500) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        build_record(3, 6, 30, -1);
        ship(rec.size(), 0);
      end else if (pick <= 12) begin
        build_record($urandom_range(0, 3), 3, 6, -1);
        ship(rec.size(), (pick < 4) ? $urandom_range(1, 4) : 0);
      end else if (pick <= 16) begin
        build_record($urandom_range(1, 3), 3, 6, -1);
        ship($urandom_range(1, rec.size() - 1), 0);
      end else begin
        // Short noise, often opening with a start code.
        n = $urandom_range(1, 6);
        lead_zero = 1'($urandom_range(0, 1));
        for (int i = 0; i < n; i++) begin
          b = 8'($urandom);
          if (lead_zero && i < 2) b = 8'h00;
          if (lead_zero && i == 2) b = 8'($urandom_range(0, 1));
          queue_byte(b, i == n - 1);
        end
      end
    end

    repeat (4) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (pending_bytes.size() != 0 || push) @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d bytes and checked %0d result words.", bytes_in, words_seen);
    $display("Records: %0d complete, %0d cut short, %0d rejected as not hvcC.",
             completes, truncs, rejects);
    if (errors == 0) begin
      $display("hevc_config_record_parser regression: pass");
    end else begin
      $display("hevc_config_record_parser regression: fail");
    end
    $finish;
  end

  initial begin
    #(12 * 600000);
    $display("Timed out with %0d words still expected.", expected_words.size());
    $display("hevc_config_record_parser regression: fail");
    $finish;
  end

endmodule
